// ===== src/usb_in_transfer_packetizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// USB IN transfer packetizer: assertion macros
// Shared helpers for the concurrent checks of the packetizer. Each macro
// samples on the rising edge of clock and is switched off during reset.
// ----------------------------------------------------------------------------
`ifndef USB_IN_TRANSFER_PACKETIZER_TOP_DEFINES_SVH
`define USB_IN_TRANSFER_PACKETIZER_TOP_DEFINES_SVH

// Same-cycle implication: when pre holds, post must hold in that cycle.
`define UITP_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("packetizer check failed");

// Next-cycle implication: when pre holds, post must hold in the next cycle.
`define UITP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("packetizer check failed");

`endif

// ===== src/uitp_pkg.sv =====
// ----------------------------------------------------------------------------
// USB IN transfer packetizer: package
// Codes, fixed field widths and the result word type shared by the
// packetizer step logic and its top level.
// ----------------------------------------------------------------------------
package uitp_pkg;

   // Fixed widths of the external fields.
   localparam int XFER_W   = 16;
   localparam int PKT_W    = 7;
   localparam int MODE_W   = 2;
   localparam int CODE_W   = 2;

   // Limits applied to the maximum packet size register.
   localparam logic [PKT_W-1:0] MIN_PACKET   = 7'd8;
   localparam logic [PKT_W-1:0] MAX_PACKET   = 7'd64;

   // Event kinds carried by an input word.
   typedef enum logic [MODE_W-1:0] {
      MODE_START   = 2'd0,
      MODE_IN_DONE = 2'd1,
      MODE_RETRY   = 2'd2,
      MODE_STALL   = 2'd3
   } mode_type;

   // Handshake answered to the next IN token.
   typedef enum logic [CODE_W-1:0] {
      HS_ACK   = 2'd0,
      HS_NAK   = 2'd1,
      HS_STALL = 2'd2
   } hs_type;

   // What a step did.
   typedef enum logic [CODE_W-1:0] {
      ACT_NONE  = 2'd0,
      ACT_ARMED = 2'd1,
      ACT_EMPTY = 2'd2
   } action_type;

   // One result word.
   typedef struct packed {
      action_type         action;
      logic [XFER_W-1:0]  offset;
      logic [PKT_W-1:0]   length;
      hs_type             response;
      logic               busy;
   } result_type;

endpackage

// ===== src/uitp_step.sv =====
// ----------------------------------------------------------------------------
// USB IN transfer packetizer: step logic
// Combinational next-state and result logic for one event: loads a new
// transfer, applies the handshake change and tries to arm the next packet.
// ----------------------------------------------------------------------------
module uitp_step #(
   parameter int LENGTH_BITS = 16
) (
   input  uitp_pkg::mode_type          mode,
   input  logic [uitp_pkg::XFER_W-1:0] transfer_length,
   input  logic                        in_buffer_empty,
   input  logic [uitp_pkg::PKT_W-1:0]  max_packet,
   input  uitp_pkg::hs_type            hs_cur,
   input  logic                        active_cur,
   input  logic [LENGTH_BITS-1:0]      total_cur,
   input  logic [LENGTH_BITS-1:0]      offset_cur,
   input  logic [uitp_pkg::PKT_W-1:0]  last_size_cur,
   input  logic                        zlp_cur,
   output uitp_pkg::hs_type            hs_nxt,
   output logic                        active_nxt,
   output logic [LENGTH_BITS-1:0]      total_nxt,
   output logic [LENGTH_BITS-1:0]      offset_nxt,
   output logic [uitp_pkg::PKT_W-1:0]  last_size_nxt,
   output logic                        zlp_nxt,
   output uitp_pkg::result_type        result
);

   // Width wide enough for both the input field and the stored length.
   localparam int WIDE_W = (LENGTH_BITS > uitp_pkg::XFER_W) ? LENGTH_BITS : uitp_pkg::XFER_W;

   logic [uitp_pkg::PKT_W-1:0] eff_max;
   logic [WIDE_W-1:0]          tlen_wide;
   logic [WIDE_W-1:0]          limit_wide;
   logic [WIDE_W-1:0]          tlen_sat_wide;
   logic [LENGTH_BITS-1:0]     tlen_sat;

   // Clamp the maximum packet size into the legal range.
   always_comb begin
      priority if (max_packet < uitp_pkg::MIN_PACKET) begin
         eff_max = uitp_pkg::MIN_PACKET;
      end else if (max_packet > uitp_pkg::MAX_PACKET) begin
         eff_max = uitp_pkg::MAX_PACKET;
      end else begin
         eff_max = max_packet;
      end
   end

   // Saturate the requested length to what the length registers hold.
   assign tlen_wide     = WIDE_W'(transfer_length);
   assign limit_wide    = WIDE_W'({LENGTH_BITS{1'b1}});
   assign tlen_sat_wide = (tlen_wide > limit_wide) ? limit_wide : tlen_wide;
   assign tlen_sat      = tlen_sat_wide[LENGTH_BITS-1:0];

   // Event decode followed by the arm attempt.
   always_comb begin
      logic                   try_arm;
      logic                   armed;
      logic [LENGTH_BITS-1:0] off_sum;
      logic [LENGTH_BITS-1:0] remaining;
      logic [LENGTH_BITS-1:0] max_ext;
      logic [WIDE_W-1:0]      off_wide;

      hs_nxt        = hs_cur;
      active_nxt    = active_cur;
      total_nxt     = total_cur;
      offset_nxt    = offset_cur;
      last_size_nxt = last_size_cur;
      zlp_nxt       = zlp_cur;
      try_arm       = 1'b0;
      armed         = 1'b0;
      result.action = uitp_pkg::ACT_NONE;

      unique case (mode)
         uitp_pkg::MODE_START: begin
            total_nxt     = tlen_sat;
            offset_nxt    = '0;
            last_size_nxt = '0;
            zlp_nxt       = 1'b0;
            active_nxt    = (tlen_sat != '0);
            if (tlen_sat == '0) begin
               hs_nxt        = uitp_pkg::HS_ACK;
               result.action = uitp_pkg::ACT_EMPTY;
            end else begin
               try_arm = 1'b1;
            end
         end
         uitp_pkg::MODE_IN_DONE: begin
            hs_nxt  = uitp_pkg::HS_NAK;
            try_arm = 1'b1;
         end
         uitp_pkg::MODE_RETRY: begin
            try_arm = 1'b1;
         end
         uitp_pkg::MODE_STALL: begin
            hs_nxt = uitp_pkg::HS_STALL;
         end
      endcase

      // Bytes left after the packet just sent.
      off_sum   = offset_nxt + LENGTH_BITS'(last_size_nxt);
      remaining = (off_sum <= total_nxt) ? (total_nxt - off_sum) : '0;
      max_ext   = LENGTH_BITS'(eff_max);

      if (try_arm && (hs_nxt == uitp_pkg::HS_NAK) && in_buffer_empty && active_nxt) begin
         offset_nxt = off_sum;
         priority if (remaining > max_ext) begin
            last_size_nxt = eff_max;
            zlp_nxt       = 1'b0;
            armed         = 1'b1;
         end else if (remaining == max_ext) begin
            // A final full packet is followed by a zero-length one.
            last_size_nxt = eff_max;
            zlp_nxt       = 1'b1;
            armed         = 1'b1;
         end else if (zlp_nxt) begin
            zlp_nxt       = 1'b0;
            last_size_nxt = '0;
            armed         = 1'b1;
         end else if (remaining == '0) begin
            // Transfer complete: return to the idle state.
            active_nxt    = 1'b0;
            total_nxt     = '0;
            offset_nxt    = '0;
            last_size_nxt = '0;
            zlp_nxt       = 1'b0;
         end else begin
            last_size_nxt = remaining[uitp_pkg::PKT_W-1:0];
            armed         = 1'b1;
         end
         if (armed) begin
            hs_nxt        = uitp_pkg::HS_ACK;
            result.action = uitp_pkg::ACT_ARMED;
         end
      end

      // Assemble the result word.
      off_wide        = WIDE_W'(offset_nxt);
      result.offset   = armed ? off_wide[uitp_pkg::XFER_W-1:0] : '0;
      result.length   = armed ? last_size_nxt : '0;
      result.response = hs_nxt;
      result.busy     = active_nxt;
   end

endmodule

// ===== src/usb_in_transfer_packetizer_top.sv =====
// ----------------------------------------------------------------------------
// USB IN transfer packetizer: top level
// Packetizer for one USB IN endpoint. Each event word gives one result word
// with the armed packet's offset and length, the handshake and busy flag.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall   mode, transfer_length,
//                                                in_buffer_empty
//   rsp_      out        rsp_valid / rsp_stall   action, packet_offset,
//                                                packet_length, response, busy_res
//   csr_      in         csr_write_enable        max_packet (7 bits)
//
// One word per cycle sustained while rsp_ does not stall; an accepted word sits in
// the input register, and its result then moves into the result register.
// The endpoint state lives next to the step logic, so back-to-back events
// see the previous event's state without any bubble.
// Reset is synchronous and active high; max_packet returns to 64.
// A stall on rsp_ holds the result register and backs up into req_stall.

`include "usb_in_transfer_packetizer_top_defines.svh"

module usb_in_transfer_packetizer_top #(
   parameter int LENGTH_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // Event input channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [uitp_pkg::MODE_W-1:0]  req_mode,
   input  logic [uitp_pkg::XFER_W-1:0]  req_transfer_length,
   input  logic                         req_in_buffer_empty,
   // Result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [uitp_pkg::CODE_W-1:0]  rsp_action,
   output logic [uitp_pkg::XFER_W-1:0]  rsp_packet_offset,
   output logic [uitp_pkg::PKT_W-1:0]   rsp_packet_length,
   output logic [uitp_pkg::CODE_W-1:0]  rsp_response,
   output logic                         rsp_busy_res,
   // Configuration
   input  logic                         csr_write_enable,
   input  logic [uitp_pkg::PKT_W-1:0]   csr_write_data
);

   // Input register.
   logic                        in_valid_ff, in_valid_in;
   uitp_pkg::mode_type          in_mode_ff;
   logic [uitp_pkg::XFER_W-1:0] in_tlen_ff;
   logic                        in_buf_ff;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   uitp_pkg::result_type        rsp_ff, rsp_in;

   // Endpoint state.
   uitp_pkg::hs_type            hs_ff, hs_in;
   logic                        active_ff, active_in;
   logic [LENGTH_BITS-1:0]      total_ff, total_in;
   logic [LENGTH_BITS-1:0]      offset_ff, offset_in;
   logic [uitp_pkg::PKT_W-1:0]  last_size_ff, last_size_in;
   logic                        zlp_ff, zlp_in;

   // Configuration register.
   logic [uitp_pkg::PKT_W-1:0]  max_packet_ff;

   logic out_free;
   logic advance;
   logic req_take;

   // Flow control: the input register moves on whenever the result
   // register is empty or being emptied.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // Step logic for the word in the input register.
   uitp_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .mode            (in_mode_ff),
      .transfer_length (in_tlen_ff),
      .in_buffer_empty (in_buf_ff),
      .max_packet      (max_packet_ff),
      .hs_cur          (hs_ff),
      .active_cur      (active_ff),
      .total_cur       (total_ff),
      .offset_cur      (offset_ff),
      .last_size_cur   (last_size_ff),
      .zlp_cur         (zlp_ff),
      .hs_nxt          (hs_in),
      .active_nxt      (active_in),
      .total_nxt       (total_in),
      .offset_nxt      (offset_in),
      .last_size_nxt   (last_size_in),
      .zlp_nxt         (zlp_in),
      .result          (rsp_in)
   );

   // Handshake flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input payload register, cleared so that the step logic never sees
   // an undefined event.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_mode_ff <= uitp_pkg::MODE_STALL;
         in_tlen_ff <= '0;
         in_buf_ff  <= 1'b0;
      end else if (req_take) begin
         in_mode_ff <= uitp_pkg::mode_type'(req_mode);
         in_tlen_ff <= req_transfer_length;
         in_buf_ff  <= req_in_buffer_empty;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Endpoint state, updated once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff        <= uitp_pkg::HS_NAK;
         active_ff    <= 1'b0;
         total_ff     <= '0;
         offset_ff    <= '0;
         last_size_ff <= '0;
         zlp_ff       <= 1'b0;
      end else if (advance) begin
         hs_ff        <= hs_in;
         active_ff    <= active_in;
         total_ff     <= total_in;
         offset_ff    <= offset_in;
         last_size_ff <= last_size_in;
         zlp_ff       <= zlp_in;
      end
   end

   // Maximum packet size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_ff <= uitp_pkg::MAX_PACKET;
      end else if (csr_write_enable) begin
         max_packet_ff <= csr_write_data;
      end
   end

   // Outputs.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_ff.action;
   assign rsp_packet_offset = rsp_ff.offset;
   assign rsp_packet_length = rsp_ff.length;
   assign rsp_response      = rsp_ff.response;
   assign rsp_busy_res      = rsp_ff.busy;

   // An armed packet always leaves the endpoint answering ACK mid-transfer.
   `UITP_ASSERT_IMPL(a_armed_ack, rsp_valid_ff && (rsp_ff.action == uitp_pkg::ACT_ARMED), (rsp_ff.response == uitp_pkg::HS_ACK) && rsp_ff.busy)
   // Words that arm nothing carry a zero offset and length.
   `UITP_ASSERT_IMPL(a_idle_zero, rsp_valid_ff && (rsp_ff.action != uitp_pkg::ACT_ARMED), (rsp_ff.offset == '0) && (rsp_ff.length == '0))
   // An empty transfer is acknowledged and leaves nothing in progress.
   `UITP_ASSERT_IMPL(a_empty_done, rsp_valid_ff && (rsp_ff.action == uitp_pkg::ACT_EMPTY), (rsp_ff.response == uitp_pkg::HS_ACK) && !rsp_ff.busy)
   // A processed word always lands in the result register.
   `UITP_ASSERT_NEXT(a_advance_lands, advance, rsp_valid_ff)

endmodule

// ===== tb/sv/uitp_result_checker.sv =====
// ----------------------------------------------------------------------------
// USB IN transfer packetizer: result checker
// Watches the event and result channels and the max_packet register port.
// Predicts one result word per accepted event word from its own model of
// the endpoint, and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module uitp_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [uitp_pkg::MODE_W-1:0] req_mode,
   input  logic [uitp_pkg::XFER_W-1:0] req_transfer_length,
   input  logic                        req_in_buffer_empty,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [uitp_pkg::CODE_W-1:0] rsp_action,
   input  logic [uitp_pkg::XFER_W-1:0] rsp_packet_offset,
   input  logic [uitp_pkg::PKT_W-1:0]  rsp_packet_length,
   input  logic [uitp_pkg::CODE_W-1:0] rsp_response,
   input  logic                        rsp_busy_res,
   input  logic                        csr_write_enable,
   input  logic [uitp_pkg::PKT_W-1:0]  csr_write_data,
   output int                          pending_results,
   output int                          error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Endpoint state as the packetizer should hold it.
   logic [uitp_pkg::PKT_W-1:0]  max_packet_reg;
   uitp_pkg::hs_type            handshake;
   logic                        xfer_busy;
   logic [uitp_pkg::XFER_W-1:0] xfer_len;
   logic [uitp_pkg::XFER_W-1:0] xfer_off;
   logic [uitp_pkg::PKT_W-1:0]  pkt_len;
   logic                        zlp_owed;

   uitp_pkg::result_type expected_results [$];
   int                   words_checked = 0;

   task automatic report_mismatch(string msg);
      $display("packetizer mismatch: %s", msg);
      error_count++;
   endtask

   // Tries to arm the next packet of the transfer; returns 1 when it did.
   function automatic logic arm_packet(logic buf_empty);
      logic [uitp_pkg::PKT_W-1:0]  limit;
      logic [uitp_pkg::XFER_W-1:0] left;
      limit = (max_packet_reg < uitp_pkg::MIN_PACKET) ? uitp_pkg::MIN_PACKET :
              (max_packet_reg > uitp_pkg::MAX_PACKET) ? uitp_pkg::MAX_PACKET :
              max_packet_reg;
      if (handshake != uitp_pkg::HS_NAK || !buf_empty || !xfer_busy) return 1'b0;
      xfer_off = xfer_off + pkt_len;
      left = (xfer_off <= xfer_len) ? xfer_len - xfer_off : '0;
      if (left > limit) begin
         pkt_len = limit;
         zlp_owed = 1'b0;
      end else if (left == limit) begin
         // An exactly full packet owes a zero-length packet after it.
         pkt_len = limit;
         zlp_owed = 1'b1;
      end else if (zlp_owed) begin
         zlp_owed = 1'b0;
         pkt_len = '0;
      end else if (left == '0) begin
         // Nothing left: the transfer ends without arming.
         xfer_busy = 1'b0;
         xfer_len = '0;
         xfer_off = '0;
         pkt_len = '0;
         zlp_owed = 1'b0;
         return 1'b0;
      end else begin
         pkt_len = left[uitp_pkg::PKT_W-1:0];
      end
      handshake = uitp_pkg::HS_ACK;
      return 1'b1;
   endfunction

   // Advances the endpoint by one event word and gives the result word.
   // The length field is as wide as LENGTH_BITS, so it never saturates.
   function automatic uitp_pkg::result_type predict_result(
      uitp_pkg::mode_type mode, logic [uitp_pkg::XFER_W-1:0] len, logic buf_empty);
      uitp_pkg::result_type res;
      res = '0;
      res.action = uitp_pkg::ACT_NONE;
      case (mode)
         uitp_pkg::MODE_START: begin
            xfer_len = len;
            xfer_off = '0;
            pkt_len = '0;
            zlp_owed = 1'b0;
            xfer_busy = (len != '0);
            if (len == '0) begin
               handshake = uitp_pkg::HS_ACK;
               res.action = uitp_pkg::ACT_EMPTY;
            end else if (arm_packet(buf_empty)) begin
               res.action = uitp_pkg::ACT_ARMED;
            end
         end
         uitp_pkg::MODE_IN_DONE: begin
            handshake = uitp_pkg::HS_NAK;
            if (arm_packet(buf_empty)) res.action = uitp_pkg::ACT_ARMED;
         end
         uitp_pkg::MODE_RETRY: begin
            if (arm_packet(buf_empty)) res.action = uitp_pkg::ACT_ARMED;
         end
         default: begin
            handshake = uitp_pkg::HS_STALL;
         end
      endcase
      if (res.action == uitp_pkg::ACT_ARMED) begin
         res.offset = xfer_off;
         res.length = pkt_len;
      end
      res.response = handshake;
      res.busy = xfer_busy;
      return res;
   endfunction

   // Everything is sampled on the rising edge, after the falling-edge drive.
   always @(posedge clock) begin
      uitp_pkg::result_type want;
      if (reset) begin
         max_packet_reg = uitp_pkg::MAX_PACKET;
         handshake = uitp_pkg::HS_NAK;
         xfer_busy = 1'b0;
         xfer_len = '0;
         xfer_off = '0;
         pkt_len = '0;
         zlp_owed = 1'b0;
         error_count = 0;
         expected_results.delete();
      end else begin
         // Result words are compared against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("word %0d arrived with no prediction waiting",
                                         words_checked));
            end else begin
               want = expected_results.pop_front();
               if (rsp_action !== want.action)
                  report_mismatch($sformatf("word %0d action %0d, expected %0d",
                                            words_checked, rsp_action, want.action));
               if (rsp_packet_offset !== want.offset)
                  report_mismatch($sformatf("word %0d packet_offset %0d, expected %0d",
                                            words_checked, rsp_packet_offset, want.offset));
               if (rsp_packet_length !== want.length)
                  report_mismatch($sformatf("word %0d packet_length %0d, expected %0d",
                                            words_checked, rsp_packet_length, want.length));
               if (rsp_response !== want.response)
                  report_mismatch($sformatf("word %0d response %0d, expected %0d",
                                            words_checked, rsp_response, want.response));
               if (rsp_busy_res !== want.busy)
                  report_mismatch($sformatf("word %0d busy_res %0d, expected %0d",
                                            words_checked, rsp_busy_res, want.busy));
            end
            words_checked++;
         end
         if (csr_write_enable) max_packet_reg = csr_write_data;
         if (req_valid && !req_stall)
            expected_results.push_back(predict_result(uitp_pkg::mode_type'(req_mode),
                                                      req_transfer_length,
                                                      req_in_buffer_empty));
      end
      pending_results = expected_results.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// USB IN transfer packetizer: testbench top
// Drives event words and max_packet writes into the packetizer, stalls the
// result channel at random, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [uitp_pkg::MODE_W-1:0] req_mode = uitp_pkg::MODE_START;
   logic [uitp_pkg::XFER_W-1:0] req_transfer_length = '0;
   logic                        req_in_buffer_empty = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [uitp_pkg::CODE_W-1:0] rsp_action;
   logic [uitp_pkg::XFER_W-1:0] rsp_packet_offset;
   logic [uitp_pkg::PKT_W-1:0]  rsp_packet_length;
   logic [uitp_pkg::CODE_W-1:0] rsp_response;
   logic                        rsp_busy_res;
   logic                        csr_write_enable = 1'b0;
   logic [uitp_pkg::PKT_W-1:0]  csr_write_data = '0;

   int pending_results;
   int error_count;

   // Idling of both sides, in percent, and the packet size now in force.
   int                         idle_pct = 0;
   int                         stall_pct = 0;
   int                         words_sent = 0;
   logic [uitp_pkg::PKT_W-1:0] pkt_size = uitp_pkg::MAX_PACKET;

   // Per-phase plans: register value, sender idling, receiver stalling.
   logic [uitp_pkg::PKT_W-1:0] size_plan [8] =
      '{7'd8, 7'd0, 7'd127, 7'd64, 7'd37, 7'd7, 7'd65, 7'd64};
   int                         idle_plan [4] = '{0, 83, 0, 35};
   int                         stall_plan [4] = '{0, 0, 83, 35};

   usb_in_transfer_packetizer_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_transfer_length (req_transfer_length),
      .req_in_buffer_empty (req_in_buffer_empty),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_packet_offset   (rsp_packet_offset),
      .rsp_packet_length   (rsp_packet_length),
      .rsp_response        (rsp_response),
      .rsp_busy_res        (rsp_busy_res),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   uitp_result_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_transfer_length (req_transfer_length),
      .req_in_buffer_empty (req_in_buffer_empty),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_packet_offset   (rsp_packet_offset),
      .rsp_packet_length   (rsp_packet_length),
      .rsp_response        (rsp_response),
      .rsp_busy_res        (rsp_busy_res),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .pending_results     (pending_results),
      .error_count         (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver stall, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Offers one event word, after an optional gap, and waits for acceptance.
   // Entered and left at a falling edge.
   task automatic send_event(uitp_pkg::mode_type mode, logic [uitp_pkg::XFER_W-1:0] len,
                             logic buf_empty);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_transfer_length <= len;
      req_in_buffer_empty <= buf_empty;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // Holds the sender back until every predicted word has come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_max_packet(logic [uitp_pkg::PKT_W-1:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      pkt_size = (value < uitp_pkg::MIN_PACKET) ? uitp_pkg::MIN_PACKET :
                 (value > uitp_pkg::MAX_PACKET) ? uitp_pkg::MAX_PACKET : value;
   endtask

   // One transfer: a start, then mostly served IN tokens with some noise.
   task automatic run_transfer();
      int pick;
      int len;
      int steps;
      pick = $urandom_range(99);
      if (pick < 8)       len = $urandom_range(3);
      else if (pick < 30) len = pkt_size * $urandom_range(1, 4);
      else if (pick < 36) len = $urandom_range(65535);
      else                len = $urandom_range(300);
      steps = (len / pkt_size) * 3 / 2 + $urandom_range(2, 5);
      if (steps > 40) steps = 40;
      send_event(uitp_pkg::MODE_START, len[uitp_pkg::XFER_W-1:0], $urandom_range(9) != 0);
      repeat (steps) begin
         pick = $urandom_range(99);
         if (pick < 78)
            send_event(uitp_pkg::MODE_IN_DONE, uitp_pkg::XFER_W'($urandom),
                       $urandom_range(9) != 0);
         else if (pick < 88)
            send_event(uitp_pkg::MODE_RETRY, uitp_pkg::XFER_W'($urandom),
                       $urandom_range(3) != 0);
         else if (pick < 95)
            send_event(uitp_pkg::MODE_STALL, uitp_pkg::XFER_W'($urandom),
                       1'($urandom_range(1)));
         else
            send_event(uitp_pkg::MODE_START, uitp_pkg::XFER_W'($urandom),
                       1'($urandom_range(1)));
      end
   endtask

   initial begin
      int ph;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset packet size of 64.
      send_event(uitp_pkg::MODE_START, 16'd0, 1'b1);     // empty transfer only acknowledges
      send_event(uitp_pkg::MODE_STALL, 16'd0, 1'b1);
      send_event(uitp_pkg::MODE_RETRY, 16'd0, 1'b1);     // stalled and idle: nothing armed
      send_event(uitp_pkg::MODE_START, 16'd130, 1'b1);
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b0);   // buffer still full
      send_event(uitp_pkg::MODE_RETRY, 16'd0, 1'b1);
      send_event(uitp_pkg::MODE_STALL, 16'd0, 1'b1);
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);   // second full packet
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);   // short final packet
      send_event(uitp_pkg::MODE_START, 16'd128, 1'b1);
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);   // first full packet
      send_event(uitp_pkg::MODE_RETRY, 16'd0, 1'b1);     // handshake is ACK: nothing armed
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);   // full final packet, zero-length packet owed
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);
      send_event(uitp_pkg::MODE_START, 16'hFFFF, 1'b0);
      send_event(uitp_pkg::MODE_RETRY, 16'hFFFF, 1'b1);
      send_event(uitp_pkg::MODE_START, 16'd1, 1'b1);     // overrides the transfer in progress
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);   // transfer end: nothing left to arm
      send_event(uitp_pkg::MODE_START, 16'd64, 1'b1);
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);
      send_event(uitp_pkg::MODE_IN_DONE, 16'd0, 1'b1);

      // Random phases, each with its own packet size and idling pattern.
      for (ph = 0; ph < 8; ph++) begin
         set_max_packet(size_plan[ph]);
         idle_pct = idle_plan[ph % 4];
         stall_pct = stall_plan[ph % 4];
         while (words_sent < 25 + ph * 200 + 100) run_transfer();
         wait_for_results();
         while (words_sent < 25 + (ph + 1) * 200) run_transfer();
      end

      stall_pct = 0;
      wait_for_results();
      repeat (8) @(negedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("[usb_in_transfer_packetizer_top] OK");
      end else begin
         $display("[usb_in_transfer_packetizer_top] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("[usb_in_transfer_packetizer_top] ERROR");
      $finish;
   end

endmodule
